/* hdl/pba_pkg.sv */
// pba_pkg: shared types and constants of the page bitmap allocator
// no dependencies; used by the interfaces and every module in hdl
package pba_pkg;

    localparam int OP_W  = 3;
    localparam int PG_W  = 12;
    localparam int CNT_W = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_FREE    = 3'd2,
        OP_LOCK    = 3'd3,
        OP_RESERVE = 3'd4
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch request fields, clear result fields
        logic init_cnt;   // counters to init values
        logic clr_wr;     // clear one bitmap entry
        logic srch_init;  // search cursor to heap start + 1
        logic rd_srch;    // read bitmap at search cursor
        logic srch_skip;  // restart run just past cursor
        logic srch_adv;   // grow run by one page
        logic srch_miss;  // flag no space
        logic set_run;    // set pass over found run (lock)
        logic set_req;    // set pass over requested run
        logic rd_set;     // read bitmap at set pointer
        logic set_step;   // write bit if it changes, move counters
        logic out_load;   // capture result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic srch_hit;
        logic srch_miss;
        logic srch_oob;
        logic rd_bit;
        logic set_end;
    } sts_t;

endpackage

/* hdl/pba_if.sv */
// pba_if: valid/ready channel interfaces for requests and results
// depends on pba_pkg
interface pba_req_if import pba_pkg::*;;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [PG_W-1:0] start_page;
    logic [CNT_W-1:0] page_count;

    modport source (output valid, operation, start_page, page_count, input ready);
    modport sink   (input valid, operation, start_page, page_count, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             status;
    logic [PG_W-1:0]  first_page;
    logic [CNT_W-1:0] free_now;
    logic [CNT_W-1:0] used_now;
    logic [CNT_W-1:0] reserved_now;

    modport source (output valid, status, first_page, free_now, used_now, reserved_now,
                    input ready);
    modport sink   (input valid, status, first_page, free_now, used_now, reserved_now,
                    output ready);
endinterface

/* hdl/page_bitmap_allocator.sv */
// page_bitmap_allocator: top level of the first-fit page bitmap allocator
// depends on pba_pkg, pba_if, pba_ctrl and pba_datapath
//
// channel   direction  payload                                         handshake
// req_ch    in         operation, start_page, page_count               valid/ready
// rsp_ch    out        status, first_page, free_now, used_now,         valid/ready
//                      reserved_now
// cfg       in         cfg_index, cfg_wdata                            cfg_we
//
// pace: one bitmap memory port (one page read per cycle, registered data) sets the pace;
//   the search reads each page it examines and then evaluates it, and a set pass reads
//   each page and then writes it only if its bit changes
// init sweeps the whole bitmap, one entry a cycle
// reset: a clearing sweep over all PAGES entries runs first; req_ch.ready stays low meanwhile
// stalls: one result register decouples the sides; a result held by rsp_ch.ready blocks
//   only the hand-over of the following result
module page_bitmap_allocator import pba_pkg::*;
#(
    parameter int PAGES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pba_req_if.sink              req_ch,
    pba_rsp_if.source            rsp_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: clearing sweep, first-fit search walk, run set pass, result hand-over
    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .operation (req_ch.operation),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // bitmap memory, page counters, cursors and the result register
    pba_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .operation    (req_ch.operation),
        .start_page   (req_ch.start_page),
        .page_count   (req_ch.page_count),
        .cmd          (cmd),
        .sts          (sts),
        .status       (rsp_ch.status),
        .first_page   (rsp_ch.first_page),
        .free_now     (rsp_ch.free_now),
        .used_now     (rsp_ch.used_now),
        .reserved_now (rsp_ch.reserved_now)
    );

endmodule

/* hdl/pba_datapath.sv */
// pba_datapath: bitmap memory, counters, search and set cursors, result registers
// depends on pba_pkg
module pba_datapath import pba_pkg::*;
#(
    parameter int PAGES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic [OP_W-1:0]      operation,
    input  logic [PG_W-1:0]      start_page,
    input  logic [CNT_W-1:0]     page_count,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 status,
    output logic [PG_W-1:0]      first_page,
    output logic [CNT_W-1:0]     free_now,
    output logic [CNT_W-1:0]     used_now,
    output logic [CNT_W-1:0]     reserved_now
);

    localparam int AW = $clog2(PAGES);
    localparam int PW = ((AW > 14) ? AW : 14) + 1;

    typedef enum logic [1:0] {
        MODE_FREE,
        MODE_LOCK,
        MODE_RSV
    } mode_t;

    logic             mem [PAGES];
    logic             rd_data_reg;
    logic [AW-1:0]    clr_ptr_reg;
    logic [PG_W-1:0]  heap_reg;
    logic [CNT_W-1:0] total_reg;
    logic [OP_W-1:0]  op_reg;
    logic [PG_W-1:0]  start_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PW-1:0]    run_start_reg;
    logic [PW-1:0]    found_reg;
    logic [PW-1:0]    ptr_reg;
    logic [CNT_W-1:0] rem_reg;
    mode_t            mode_reg;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] rsv_reg;
    logic             status_reg;
    logic [PG_W-1:0]  first_reg;
    logic             miss_reg;
    logic [PG_W-1:0]  hit_page_reg;
    logic [CNT_W-1:0] free_out_reg;
    logic [CNT_W-1:0] used_out_reg;
    logic [CNT_W-1:0] rsv_out_reg;

    logic [PW-1:0]    tot;
    logic [PW-1:0]    total_ext;
    logic [PW-1:0]    pages_c;
    logic [PW-1:0]    probe;
    logic             set_val;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             change;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    assign total_ext = PW'(total_reg);
    assign pages_c   = PW'(PAGES);
    assign tot       = (total_ext < pages_c) ? total_ext : pages_c;
    assign probe     = run_start_reg + found_reg;
    assign set_val   = (mode_reg != MODE_FREE);
    assign change    = (rd_data_reg != set_val);

    assign sts.clr_last  = (clr_ptr_reg == AW'(PAGES - 1));
    assign sts.srch_hit  = (found_reg == PW'(count_reg));
    assign sts.srch_miss = (run_start_reg >= tot);
    assign sts.srch_oob  = (probe >= tot);
    assign sts.rd_bit    = rd_data_reg;
    assign sts.set_end   = (rem_reg == '0) || (ptr_reg >= tot);

    always_comb
    begin
        wr_en   = cmd.clr_wr || (cmd.set_step && change);
        wr_addr = cmd.clr_wr ? clr_ptr_reg : ptr_reg[AW-1:0];
        wr_data = cmd.clr_wr ? 1'b0 : set_val;
        rd_en   = cmd.rd_srch || cmd.rd_set;
        rd_addr = cmd.rd_srch ? probe[AW-1:0] : ptr_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg   <= '0;
            heap_reg      <= '0;
            total_reg     <= CNT_W'(4096);
            free_reg      <= '0;
            used_reg      <= '0;
            rsv_reg       <= '0;
            found_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEAP_START:  heap_reg  <= cfg_wdata[PG_W-1:0];
                    CFG_TOTAL_PAGES: total_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (cmd.clr_wr)
            begin
                clr_ptr_reg <= sts.clr_last ? '0 : clr_ptr_reg + 1'b1;
            end
            if (cmd.init_cnt)
            begin
                free_reg <= tot[CNT_W-1:0];
                used_reg <= '0;
                rsv_reg  <= '0;
            end
            if (cmd.load)
            begin
                count_reg <= page_count;
            end
            if (cmd.srch_init || cmd.srch_skip)
            begin
                found_reg <= '0;
            end
            else if (cmd.srch_adv)
            begin
                found_reg <= found_reg + 1'b1;
            end
            if (cmd.set_step && change)
            begin
                unique case (mode_reg)
                    MODE_FREE:
                    begin
                        used_reg <= sat_dec(used_reg);
                        free_reg <= sat_inc(free_reg);
                    end
                    MODE_LOCK:
                    begin
                        free_reg <= sat_dec(free_reg);
                        used_reg <= sat_inc(used_reg);
                    end
                    MODE_RSV:
                    begin
                        free_reg <= sat_dec(free_reg);
                        rsv_reg  <= sat_inc(rsv_reg);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            start_reg    <= start_page;
            miss_reg     <= 1'b0;
            hit_page_reg <= '0;
        end
        if (cmd.srch_init)
        begin
            run_start_reg <= PW'(heap_reg) + 1'b1;
        end
        else if (cmd.srch_skip)
        begin
            run_start_reg <= probe + 1'b1;
        end
        if (cmd.srch_miss)
        begin
            miss_reg <= 1'b1;
        end
        if (cmd.set_run)
        begin
            ptr_reg      <= run_start_reg;
            rem_reg      <= count_reg;
            mode_reg     <= MODE_LOCK;
            hit_page_reg <= run_start_reg[PG_W-1:0];
        end
        else if (cmd.set_req)
        begin
            ptr_reg <= PW'(start_reg);
            rem_reg <= count_reg;
            priority case (op_reg)
                OP_FREE:    mode_reg <= MODE_FREE;
                OP_RESERVE: mode_reg <= MODE_RSV;
                default:    mode_reg <= MODE_LOCK;
            endcase
        end
        else if (cmd.set_step)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            status_reg   <= miss_reg;
            first_reg    <= hit_page_reg;
            free_out_reg <= free_reg;
            used_out_reg <= used_reg;
            rsv_out_reg  <= rsv_reg;
        end
    end

    assign status       = status_reg;
    assign first_page   = first_reg;
    assign free_now     = free_out_reg;
    assign used_now     = used_out_reg;
    assign reserved_now = rsv_out_reg;

    // a run never grows past the requested length
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_adv |-> (found_reg < PW'(count_reg)))
        else $error("search run longer than request");

    // bitmap writes from a set pass stay inside the tracked pages
    a_set_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_step |-> (ptr_reg < tot) && (rem_reg != '0))
        else $error("set pass beyond run or total");

    // clearing sweep never shares a cycle with a set pass or a search read
    a_wr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_wr && (cmd.set_step || cmd.rd_set || cmd.rd_srch)))
        else $error("clear sweep overlaps another bitmap access");

endmodule

/* hdl/pba_ctrl.sv */
// pba_ctrl: sequencer for clearing, first-fit search and run updates
// depends on pba_pkg
module pba_ctrl import pba_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [OP_W-1:0] operation,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SRCH,
        S_SEVAL,
        S_SET,
        S_SWR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   init_pend_reg, init_pend_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   phase_wr_reg, phase_wr_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        init_pend_next = init_pend_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next     = init_pend_reg ? S_DONE : S_IDLE;
                    init_pend_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (operation)
                        OP_INIT:
                        begin
                            cmd.init_cnt   = 1'b1;
                            init_pend_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        OP_ALLOC:
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                        OP_FREE, OP_LOCK, OP_RESERVE:
                        begin
                            state_next = S_SET;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                priority if (sts.srch_hit && !sts.srch_miss)
                begin
                    cmd.set_run = 1'b1;
                    state_next  = S_SWR;
                end
                else if (sts.srch_miss)
                begin
                    cmd.srch_miss = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.srch_oob)
                begin
                    cmd.srch_skip = 1'b1;
                end
                else
                begin
                    cmd.rd_srch = 1'b1;
                    state_next  = S_SEVAL;
                end
            end
            S_SEVAL:
            begin
                if (sts.rd_bit)
                begin
                    cmd.srch_skip = 1'b1;
                end
                else
                begin
                    cmd.srch_adv = 1'b1;
                end
                state_next = S_SRCH;
            end
            S_SET:
            begin
                // first visit after a request loads the set pointer
                cmd.set_req = 1'b1;
                state_next  = S_SWR;
            end
            S_SWR:
            begin
                // reuse: read phase when not yet read, write phase after
                state_next = S_SWR;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_SWR)
        begin
            cmd = '0;
            if (phase_wr_reg)
            begin
                cmd.set_step = 1'b1;
            end
            else if (sts.set_end)
            begin
                state_next = S_DONE;
            end
            else
            begin
                cmd.rd_set = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_wr_next = 1'b0;
        if ((state_reg == S_SWR) && !phase_wr_reg && !sts.set_end)
        begin
            phase_wr_next = 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            phase_wr_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_pend_reg <= init_pend_next;
            rsp_valid_reg <= rsp_valid_next;
            phase_wr_reg  <= phase_wr_next;
        end
    end

    // a captured result is presented in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp_valid)
        else $error("result captured but not presented");

    // an accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");

    // the clearing sweep only ends on its last entry
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> (state_reg == S_CLEAR) || $past(sts.clr_last))
        else $error("clearing sweep ended early");

endmodule
